// ----- src/oet_pkg.sv -----
// oet_pkg: shared types and codes for the ordered endpoint table
// holds command and status codes, the stored entry layout and the sequencer states
// no dependencies
`timescale 1ns / 1ps

package oet_pkg;

    localparam int ADDR_W  = 32;
    localparam int PORT_W  = 16;
    localparam int IDX_W   = 4;
    localparam int CNT_W   = 5;
    localparam int CMD_W   = 2;
    localparam int STAT_W  = 2;
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 32;

    // request commands
    typedef enum logic [CMD_W-1:0] {
        CMD_ADD       = 2'd0,
        CMD_FIND      = 2'd1,
        CMD_FIND_ADDR = 2'd2,
        CMD_DELETE    = 2'd3
    } t_cmd;

    // result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_DUP  = 2'd2,
        ST_FULL = 2'd3
    } t_status;

    // one stored endpoint
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [PORT_W-1:0] port;
    } t_entry;

    // sequencer states, one-hot
    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_SHIFT = 4'b0100,
        S_RESP  = 4'b1000
    } t_state;

endpackage

// ----- src/oet_store.sv -----
// oet_store: entry memory of the ordered endpoint table
// one write port and one read port with registered read data
// depends on oet_pkg for the entry layout
`timescale 1ns / 1ps

module oet_store #(
    parameter int DEPTH = 16,
    parameter int IW    = 4
) (
    input  logic                i_clk,
    input  logic                i_we,
    input  logic [IW-1:0]       i_waddr,
    input  oet_pkg::t_entry     i_wdata,
    input  logic [IW-1:0]       i_raddr,
    output oet_pkg::t_entry     o_rdata
);

    oet_pkg::t_entry r_mem [DEPTH];
    oet_pkg::t_entry r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/ordered_endpoint_table.sv -----
// ordered_endpoint_table: insertion-ordered table of (address, port) endpoints
// sequencer with one compare unit walking the entry memory in oet_store
// depends on oet_pkg and oet_store
`timescale 1ns / 1ps

// channel   direction  signals                       contents
// request   in         s_axis_tvalid/tready/tdata/tuser  command, address, port
// result    out        m_axis_tvalid/tready/tdata/tuser  status, index, port, count
//
// one request at a time: accept, then a scan of the stored entries; a delete then
// moves the later entries down one per cycle, and the result is sent last
// reset is synchronous, active low, and empties the table
// a result waiting in the output register holds the next result in the sequencer,
// which then accepts no request until the waiting result is taken

module ordered_endpoint_table #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // [31:0] address, [47:32] port_number
    input  logic [1:0]  s_axis_tuser,   // [1:0] command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [3:0] entry_index, [19:4] matched_port,
                                        // [24:20] entry_count, rest zero
    output logic [1:0]  m_axis_tuser    // [1:0] status
);

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int PW = oet_pkg::PORT_W;

    oet_pkg::t_state  r_state, n_state;
    oet_pkg::t_cmd    r_cmd, n_cmd;
    oet_pkg::t_entry  r_key, n_key;
    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    r_ptr, n_ptr;
    logic             r_rd_vld, n_rd_vld;
    logic [IW-1:0]    r_rd_idx, n_rd_idx;
    oet_pkg::t_status r_res_status, n_res_status;
    logic [IW-1:0]    r_res_idx, n_res_idx;
    logic [PW-1:0]    r_res_port, n_res_port;
    logic             r_m_valid, n_m_valid;
    logic [31:0]      r_m_tdata, n_m_tdata;
    logic [1:0]       r_m_tuser, n_m_tuser;

    logic             mem_we;
    logic [IW-1:0]    mem_waddr;
    oet_pkg::t_entry  mem_wdata;
    oet_pkg::t_entry  mem_rdata;
    logic             issue;
    logic             match;
    logic             addr_only;
    logic [IW+3:0]    idx_ext;
    logic [CW+4:0]    cnt_ext;

    oet_store #(
        .DEPTH (TABLE_DEPTH),
        .IW    (IW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (r_ptr[IW-1:0]),
        .o_rdata (mem_rdata)
    );

    // read issue and compare of the entry read last cycle
    assign issue     = (r_ptr < r_count);
    assign addr_only = (r_cmd == oet_pkg::CMD_FIND_ADDR) || (r_cmd == oet_pkg::CMD_DELETE);
    assign match     = r_rd_vld && (mem_rdata.addr == r_key.addr)
                       && (addr_only || (mem_rdata.port == r_key.port));

    // result fields zero-extended, cut to their field widths when the output is built
    assign idx_ext = {4'b0, r_res_idx};
    assign cnt_ext = {5'b0, r_count};

    assign s_axis_tready = (r_state == oet_pkg::S_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_tdata;
    assign m_axis_tuser  = r_m_tuser;

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_key        = r_key;
        n_count      = r_count;
        n_ptr        = r_ptr;
        n_rd_vld     = r_rd_vld;
        n_rd_idx     = r_rd_idx;
        n_res_status = r_res_status;
        n_res_idx    = r_res_idx;
        n_res_port   = r_res_port;
        n_m_valid    = r_m_valid;
        n_m_tdata    = r_m_tdata;
        n_m_tuser    = r_m_tuser;
        mem_we       = 1'b0;
        mem_waddr    = r_rd_idx - 1'b1;
        mem_wdata    = mem_rdata;

        // result taken downstream
        if (r_m_valid && m_axis_tready) begin
            n_m_valid = 1'b0;
        end

        case (r_state)
            oet_pkg::S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_cmd      = oet_pkg::t_cmd'(s_axis_tuser);
                    n_key.addr = s_axis_tdata[31:0];
                    n_key.port = s_axis_tdata[47:32];
                    n_ptr      = '0;
                    n_rd_vld   = 1'b0;
                    n_state    = oet_pkg::S_SCAN;
                end
            end
            oet_pkg::S_SCAN: begin
                n_rd_vld = issue;
                if (issue) begin
                    n_ptr    = r_ptr + 1'b1;
                    n_rd_idx = r_ptr[IW-1:0];
                end
                if (match) begin
                    n_res_idx  = r_rd_idx;
                    n_res_port = '0;
                    case (r_cmd)
                        oet_pkg::CMD_ADD: begin
                            n_res_status = oet_pkg::ST_DUP;
                            n_state      = oet_pkg::S_RESP;
                        end
                        oet_pkg::CMD_FIND, oet_pkg::CMD_FIND_ADDR: begin
                            n_res_status = oet_pkg::ST_OK;
                            n_res_port   = mem_rdata.port;
                            n_state      = oet_pkg::S_RESP;
                        end
                        default: begin
                            // delete: the read of the next entry is already in flight
                            n_res_status = oet_pkg::ST_OK;
                            n_state      = oet_pkg::S_SHIFT;
                        end
                    endcase
                end else if (!r_rd_vld && !issue) begin
                    // whole table walked without a hit
                    n_res_port = '0;
                    n_res_idx  = '0;
                    n_state    = oet_pkg::S_RESP;
                    if (r_cmd == oet_pkg::CMD_ADD) begin
                        if (r_count >= CW'(TABLE_DEPTH)) begin
                            n_res_status = oet_pkg::ST_FULL;
                        end else begin
                            mem_we       = 1'b1;
                            mem_waddr    = r_count[IW-1:0];
                            mem_wdata    = r_key;
                            n_res_idx    = r_count[IW-1:0];
                            n_count      = r_count + 1'b1;
                            n_res_status = oet_pkg::ST_OK;
                        end
                    end else begin
                        n_res_status = oet_pkg::ST_MISS;
                    end
                end
            end
            oet_pkg::S_SHIFT: begin
                // move each later entry down one place
                n_rd_vld = issue;
                if (issue) begin
                    n_ptr    = r_ptr + 1'b1;
                    n_rd_idx = r_ptr[IW-1:0];
                end
                if (r_rd_vld) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_rd_idx - 1'b1;
                    mem_wdata = mem_rdata;
                end else if (!issue) begin
                    n_count = r_count - 1'b1;
                    n_state = oet_pkg::S_RESP;
                end
            end
            oet_pkg::S_RESP: begin
                if (!r_m_valid || m_axis_tready) begin
                    n_m_valid = 1'b1;
                    n_m_tuser = r_res_status;
                    n_m_tdata = {7'b0, cnt_ext[4:0], r_res_port, idx_ext[3:0]};
                    n_state   = oet_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = oet_pkg::S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= oet_pkg::S_IDLE;
            r_count   <= '0;
            r_rd_vld  <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_rd_vld  <= n_rd_vld;
            r_m_valid <= n_m_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_key        <= n_key;
        r_ptr        <= n_ptr;
        r_rd_idx     <= n_rd_idx;
        r_res_status <= n_res_status;
        r_res_idx    <= n_res_idx;
        r_res_port   <= n_res_port;
        r_m_tdata    <= n_m_tdata;
        r_m_tuser    <= n_m_tuser;
    end

endmodule

// ----- tb/tb_ordered_endpoint_table.sv -----
// tb_ordered_endpoint_table: self-checking bench for the ordered endpoint table
// predicts every result from its own copy of the table and checks it on the result stream
// depends on oet_pkg and ordered_endpoint_table
`timescale 1ns / 1ps

module tb_ordered_endpoint_table;

    localparam int TABLE_DEPTH    = 16;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 60;

    typedef struct {
        oet_pkg::t_status status;
        logic [3:0] idx;
        logic [15:0] port;
        logic [4:0] count;
    } t_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;   // [31:0] address, [47:32] port_number
    logic [1:0]  s_axis_tuser;   // [1:0] command
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // [3:0] entry_index, [19:4] matched_port, [24:20] entry_count
    logic [1:0]  m_axis_tuser;   // [1:0] status

    // shadow copy of the table
    logic [31:0] tbl_addr [TABLE_DEPTH];
    logic [15:0] tbl_port [TABLE_DEPTH];
    int          tbl_count;

    t_result     expected_q [$];
    logic [31:0] addr_pool [6];
    logic [15:0] port_pool [4];

    int  errors     = 0;
    int  n_sent     = 0;
    int  n_checked  = 0;
    int  n_full     = 0;
    int  n_dup      = 0;
    int  n_miss     = 0;
    int  burst_left = 0;
    bit  hold_off_req = 1'b0;

    ordered_endpoint_table #(.TABLE_DEPTH(TABLE_DEPTH)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // apply one command to the shadow table and return its result
    function automatic t_result predict_table_op(oet_pkg::t_cmd cmd, logic [31:0] a,
                                                 logic [15:0] p);
        t_result r;
        int      hit;
        int      k;
        r.status = oet_pkg::ST_MISS;
        r.idx    = '0;
        r.port   = '0;
        hit      = -1;
        for (k = 0; k < tbl_count; k++) begin
            if (hit < 0 && tbl_addr[k] == a &&
                (cmd == oet_pkg::CMD_FIND_ADDR || cmd == oet_pkg::CMD_DELETE ||
                 tbl_port[k] == p))
                hit = k;
        end
        case (cmd)
            oet_pkg::CMD_ADD: begin
                // duplicate check wins over the full check
                if (hit >= 0) begin
                    r.status = oet_pkg::ST_DUP;
                    r.idx    = hit[3:0];
                end else if (tbl_count >= TABLE_DEPTH) begin
                    r.status = oet_pkg::ST_FULL;
                end else begin
                    tbl_addr[tbl_count] = a;
                    tbl_port[tbl_count] = p;
                    r.idx    = tbl_count[3:0];
                    r.status = oet_pkg::ST_OK;
                    tbl_count++;
                end
            end
            oet_pkg::CMD_FIND, oet_pkg::CMD_FIND_ADDR: begin
                if (hit >= 0) begin
                    r.status = oet_pkg::ST_OK;
                    r.idx    = hit[3:0];
                    r.port   = tbl_port[hit];
                end
            end
            default: begin
                // delete closes the gap so order is kept
                if (hit >= 0) begin
                    for (k = hit; k + 1 < tbl_count; k++) begin
                        tbl_addr[k] = tbl_addr[k+1];
                        tbl_port[k] = tbl_port[k+1];
                    end
                    tbl_count--;
                    r.status = oet_pkg::ST_OK;
                    r.idx    = hit[3:0];
                end
            end
        endcase
        r.count = tbl_count[4:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] expv, logic [31:0] gotv);
        errors++;
        $display("[%0t] mismatch on %s: expected %0h, got %0h", $time, what, expv, gotv);
    endtask

    // predict on every accepted request
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            expected_q.push_back(predict_table_op(oet_pkg::t_cmd'(s_axis_tuser),
                                                  s_axis_tdata[31:0], s_axis_tdata[47:32]));
    end

    // check every accepted result against the oldest prediction
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            n_checked++;
            case (m_axis_tuser)
                oet_pkg::ST_FULL: n_full++;
                oet_pkg::ST_DUP:  n_dup++;
                oet_pkg::ST_MISS: n_miss++;
                default: ;
            endcase
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected result", 32'h0, m_axis_tdata);
            end else begin
                want = expected_q.pop_front();
                if (m_axis_tuser !== want.status)
                    report_mismatch("status", 32'(want.status), 32'(m_axis_tuser));
                if (m_axis_tdata[3:0] !== want.idx)
                    report_mismatch("entry_index", 32'(want.idx), 32'(m_axis_tdata[3:0]));
                if (m_axis_tdata[19:4] !== want.port)
                    report_mismatch("matched_port", 32'(want.port), 32'(m_axis_tdata[19:4]));
                if (m_axis_tdata[24:20] !== want.count)
                    report_mismatch("entry_count", 32'(want.count),
                                    32'(m_axis_tdata[24:20]));
                if (m_axis_tdata[31:25] !== 7'h0)
                    report_mismatch("tdata padding", 32'h0, 32'(m_axis_tdata[31:25]));
            end
        end
    end

    // receiver: segments of always ready, random and mostly stalled, plus a long hold on request
    initial begin
        int mode;
        int seg;
        int hold_cnt;
        m_axis_tready = 1'b0;
        hold_cnt      = 0;
        forever begin
            mode = $urandom_range(0, 2);
            seg  = $urandom_range(1, 64);
            repeat (seg) begin
                @(negedge i_clk);
                if (hold_off_req) begin
                    m_axis_tready <= 1'b0;
                    hold_cnt++;
                    if (hold_cnt >= HOLD_CYCLES) begin
                        hold_off_req = 1'b0;
                        hold_cnt     = 0;
                    end
                end else begin
                    case (mode)
                        0:       m_axis_tready <= 1'b1;
                        1:       m_axis_tready <= 1'($urandom_range(0, 1));
                        default: m_axis_tready <= ($urandom_range(0, 3) == 0);
                    endcase
                end
            end
        end
    end

    // watchdog on cycles with no transfer on either side
    initial begin
        int idle;
        idle = 0;
        forever begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle = 0;
            else
                idle++;
            if (idle >= WATCHDOG_LIMIT)
                break;
        end
        $display("[%0t] watchdog: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // send one request, with a random gap between bursts
    task automatic send_request(oet_pkg::t_cmd cmd, logic [31:0] a, logic [15:0] p);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 24);
            repeat (gap) begin
                @(negedge i_clk);
                s_axis_tvalid <= 1'b0;
            end
        end
        burst_left--;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {p, a};
        s_axis_tuser  <= cmd;
        do @(posedge i_clk); while (!s_axis_tready);
        n_sent++;
    endtask

    // stop sending until every predicted result has come back
    task automatic wait_drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0)
            @(negedge i_clk);
        burst_left = 0;
    endtask

    // one random request, biased toward stored entries and a small address pool
    task automatic send_random(int add_pct, int del_pct);
        oet_pkg::t_cmd cmd;
        logic [31:0]   a;
        logic [15:0]   p;
        int            pick;
        int            k;
        pick = $urandom_range(0, 99);
        if (pick < add_pct)
            cmd = oet_pkg::CMD_ADD;
        else if (pick < add_pct + del_pct)
            cmd = oet_pkg::CMD_DELETE;
        else if (pick[0])
            cmd = oet_pkg::CMD_FIND;
        else
            cmd = oet_pkg::CMD_FIND_ADDR;
        pick = $urandom_range(0, 99);
        if (pick < 45 && tbl_count > 0) begin
            k = $urandom_range(0, tbl_count - 1);
            a = tbl_addr[k];
            p = tbl_port[k];
        end else if (pick < 80) begin
            a = addr_pool[$urandom_range(0, 5)];
            p = port_pool[$urandom_range(0, 3)];
        end else begin
            a = $urandom;
            p = 16'($urandom_range(0, 16'hFFFF));
        end
        send_request(cmd, a, p);
    endtask

    // finds and deletes on an empty table
    task automatic test_empty_table();
        send_request(oet_pkg::CMD_FIND, 32'h0, 16'h0);
        send_request(oet_pkg::CMD_FIND_ADDR, 32'hFFFF_FFFF, 16'hFFFF);
        send_request(oet_pkg::CMD_DELETE, 32'h1234_5678, 16'h0);
        wait_drain();
    endtask

    // extreme pairs, duplicates, same address with another port, then a full table
    task automatic test_fill_and_full();
        int k;
        send_request(oet_pkg::CMD_ADD, 32'h0, 16'h0);
        send_request(oet_pkg::CMD_ADD, 32'hFFFF_FFFF, 16'hFFFF);
        send_request(oet_pkg::CMD_ADD, 32'hFFFF_FFFF, 16'hFFFF);
        send_request(oet_pkg::CMD_ADD, 32'hFFFF_FFFF, 16'h0);
        for (k = 0; k < TABLE_DEPTH - 3; k++)
            send_request(oet_pkg::CMD_ADD, 32'h0A00_0000 + k, 16'(16'h1000 + k));
        send_request(oet_pkg::CMD_ADD, 32'h0B00_0000, 16'h0001);
        send_request(oet_pkg::CMD_ADD, 32'h0, 16'h0);
        wait_drain();
    endtask

    // exact and address-only lookups, hit and miss
    task automatic test_lookups();
        send_request(oet_pkg::CMD_FIND, 32'hFFFF_FFFF, 16'h0);
        send_request(oet_pkg::CMD_FIND, 32'hFFFF_FFFF, 16'h1234);
        send_request(oet_pkg::CMD_FIND_ADDR, 32'hFFFF_FFFF, 16'h0);
        wait_drain();
    endtask

    // deletes keep order: the later entry with the same address moves up
    task automatic test_delete_order();
        send_request(oet_pkg::CMD_DELETE, 32'hFFFF_FFFF, 16'hFFFF);
        send_request(oet_pkg::CMD_FIND_ADDR, 32'hFFFF_FFFF, 16'hFFFF);
        send_request(oet_pkg::CMD_DELETE, 32'h0, 16'h0);
        send_request(oet_pkg::CMD_DELETE, 32'h0A00_0000 + TABLE_DEPTH - 4, 16'h0);
        wait_drain();
    endtask

    // receiver holds off for a long stretch while requests keep coming
    task automatic test_backpressure();
        int k;
        hold_off_req = 1'b1;
        for (k = 0; k < 40; k++)
            send_random(40, 20);
        wait_drain();
    endtask

    // rounds of fill-heavy, mixed and drain-heavy traffic, with the backpressure test after the second round
    task automatic test_random_traffic(int rounds);
        int r;
        int k;
        for (r = 0; r < rounds; r++) begin
            for (k = 0; k < 140; k++)
                send_random(65, 10);
            wait_drain();
            for (k = 0; k < 140; k++)
                send_random(30, 30);
            for (k = 0; k < 120; k++)
                send_random(10, 60);
            wait_drain();
            if (r == 1)
                test_backpressure();
        end
    endtask

    // main sequence
    initial begin
        int k;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = oet_pkg::CMD_ADD;
        tbl_count     = 0;
        addr_pool[0]  = 32'h0;
        addr_pool[1]  = 32'hFFFF_FFFF;
        for (k = 2; k < 6; k++)
            addr_pool[k] = $urandom;
        port_pool[0]  = 16'h0;
        port_pool[1]  = 16'hFFFF;
        port_pool[2]  = 16'($urandom_range(0, 16'hFFFF));
        port_pool[3]  = 16'($urandom_range(0, 16'hFFFF));

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_table();
        test_fill_and_full();
        test_lookups();
        test_delete_order();
        test_random_traffic(4);

        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (expected_q.size() != 0)
            report_mismatch("results never delivered", 32'(expected_q.size()), 32'h0);

        $display("covered %0d requests and %0d results: %0d table full, %0d duplicate, %0d miss",
                 n_sent, n_checked, n_full, n_dup, n_miss);
        $display("%0d mismatches", errors);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
